>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants for the sortable cost deque: size defaults, transfer field
// widths, action codes and error codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scd_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int REF_BITS_DEF  = 16;
    localparam int COST_BITS_DEF = 32;

    // Widths of the transfer fields.
    localparam int ACTION_W = 3;
    localparam int IREF_W   = 16;
    localparam int ICOST_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int ERR_W    = 2;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SORT       = 3'd4;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd2;

endpackage

>>> rtl/core/sortable_cost_deque.sv
// ----------------------------------------------------------------------------
// sortable_cost_deque
// Bounded deque of (cell handle, cost) entries with a stable sort by cost.
// ----------------------------------------------------------------------------
// The entries live in one simple dual-port memory used as a ring buffer: a
// head pointer marks the front and a count gives the fill, so clear, push at
// either end and pop only move the pointer or write one entry. Every accepted
// action produces exactly one result transfer describing the list afterwards.
// Every action passes through the front-read and result states; the result
// state waits while an earlier result is stalled on the output. Sort is an
// insertion sort through the memory port: each entry after the first is read
// as the key, larger entries in front of it move one position back, and the
// key is written into its place; the single read port paces it. One action
// is processed at a time; input stall is high while an action is in
// progress, but a finished result may sit in the output register while the
// next input transfer is taken. Memory content has no reset; an empty list
// reports zero front fields although the head slot is still read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sortable_cost_deque #(
    parameter int CAPACITY  = scd_pkg::CAPACITY_DEF,
    parameter int REF_BITS  = scd_pkg::REF_BITS_DEF,
    parameter int COST_BITS = scd_pkg::COST_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [scd_pkg::ACTION_W-1:0] action,
    input  logic [scd_pkg::IREF_W-1:0]   item_ref,
    input  logic [scd_pkg::ICOST_W-1:0]  item_cost,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [scd_pkg::IREF_W-1:0]   front_handle,
    output logic [scd_pkg::ICOST_W-1:0]  front_cost,
    output logic [scd_pkg::COUNT_W-1:0]  entry_count,
    output logic                         is_empty,
    output logic [scd_pkg::ERR_W-1:0]    error_code
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = REF_BITS + COST_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT_RD,
        ST_RESULT,
        ST_SRT_RD_KEY,
        ST_SRT_LD_KEY,
        ST_SRT_CMP,
        ST_SRT_PUT
    } state_t;

    // Entry storage: handle in the upper bits, cost in the lower bits.
    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rd_data_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                head_reg, head_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [scd_pkg::ERR_W-1:0]    err_reg, err_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [EW-1:0]                key_reg, key_next;
    logic                         out_valid_reg, out_valid_next;
    logic [scd_pkg::IREF_W-1:0]   front_handle_reg, front_handle_next;
    logic [scd_pkg::ICOST_W-1:0]  front_cost_reg, front_cost_next;
    logic [scd_pkg::COUNT_W-1:0]  count_out_reg, count_out_next;
    logic                         empty_reg, empty_next;
    logic [scd_pkg::ERR_W-1:0]    err_out_reg, err_out_next;

    logic [63:0]   in_ref64;
    logic [63:0]   in_cost64;
    logic [EW-1:0] in_entry;
    logic [63:0]   rd_ref64;
    logic [63:0]   rd_cost64;
    logic [31:0]   cnt32;
    logic [CW-1:0] i_inc;

    // Physical slot of a logical position counted from the front.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        begin
            sum = (CW+1)'(head) + (CW+1)'(idx);
            if (sum >= (CW+1)'(CAPACITY))
            begin
                sum = sum - (CW+1)'(CAPACITY);
            end
            return sum[AW-1:0];
        end
    endfunction

    assign in_ref64  = 64'(item_ref);
    assign in_cost64 = 64'(item_cost);
    assign in_entry  = {in_ref64[REF_BITS-1:0], in_cost64[COST_BITS-1:0]};
    assign rd_ref64  = 64'(rd_data_reg[EW-1:COST_BITS]);
    assign rd_cost64 = 64'(rd_data_reg[COST_BITS-1:0]);
    assign cnt32     = 32'(cnt_reg);
    assign i_inc     = i_reg + CW'(1);

    // Only the idle state takes a new action.
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        cnt_next          = cnt_reg;
        err_next          = err_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        key_next          = key_reg;
        out_valid_next    = out_valid_reg && out_stall;
        front_handle_next = front_handle_reg;
        front_cost_next   = front_cost_reg;
        count_out_next    = count_out_reg;
        empty_next        = empty_reg;
        err_out_next      = err_out_reg;
        wr_en             = 1'b0;
        wr_addr           = phys(head_reg, cnt_reg);
        wr_data           = in_entry;
        rd_addr           = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    err_next   = scd_pkg::ERR_NONE;
                    state_next = ST_FRONT_RD;
                    case (action)
                        scd_pkg::ACT_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        scd_pkg::ACT_PUSH_FRONT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                err_next = scd_pkg::ERR_PUSH_FULL;
                            end
                            else
                            begin
                                head_next = (head_reg == '0) ? AW'(CAPACITY - 1)
                                                             : head_reg - AW'(1);
                                wr_en     = 1'b1;
                                wr_addr   = head_next;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        scd_pkg::ACT_PUSH_BACK:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                err_next = scd_pkg::ERR_PUSH_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = phys(head_reg, cnt_reg);
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        scd_pkg::ACT_POP_FRONT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                err_next = scd_pkg::ERR_POP_EMPTY;
                            end
                            else
                            begin
                                head_next = phys(head_reg, CW'(1));
                                cnt_next  = cnt_reg - CW'(1);
                            end
                        end
                        scd_pkg::ACT_SORT:
                        begin
                            if (cnt_reg > CW'(1))
                            begin
                                i_next     = CW'(1);
                                state_next = ST_SRT_RD_KEY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_FRONT_RD:
            begin
                // The read address defaults to the head slot.
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next    = 1'b1;
                    front_handle_next = (cnt_reg != '0) ? rd_ref64[scd_pkg::IREF_W-1:0] : '0;
                    front_cost_next   = (cnt_reg != '0) ? rd_cost64[scd_pkg::ICOST_W-1:0] : '0;
                    count_out_next    = cnt32[scd_pkg::COUNT_W-1:0];
                    empty_next        = (cnt_reg == '0);
                    err_out_next      = err_reg;
                    state_next        = ST_IDLE;
                end
            end

            ST_SRT_RD_KEY:
            begin
                rd_addr    = phys(head_reg, i_reg);
                state_next = ST_SRT_LD_KEY;
            end

            ST_SRT_LD_KEY:
            begin
                key_next   = rd_data_reg;
                j_next     = i_reg;
                rd_addr    = phys(head_reg, i_reg - CW'(1));
                state_next = ST_SRT_CMP;
            end

            ST_SRT_CMP:
            begin
                // rd_data_reg holds the entry just in front of position j.
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, j_reg);
                if (rd_data_reg[COST_BITS-1:0] > key_reg[COST_BITS-1:0])
                begin
                    wr_data = rd_data_reg;
                    j_next  = j_reg - CW'(1);
                    if (j_reg > CW'(1))
                    begin
                        rd_addr = phys(head_reg, j_reg - CW'(2));
                    end
                    else
                    begin
                        state_next = ST_SRT_PUT;
                    end
                end
                else
                begin
                    wr_data    = key_reg;
                    i_next     = i_inc;
                    state_next = (i_inc < cnt_reg) ? ST_SRT_RD_KEY : ST_FRONT_RD;
                end
            end

            ST_SRT_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, j_reg);
                wr_data    = key_reg;
                i_next     = i_inc;
                state_next = (i_inc < cnt_reg) ? ST_SRT_RD_KEY : ST_FRONT_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            cnt_reg          <= '0;
            err_reg          <= scd_pkg::ERR_NONE;
            i_reg            <= '0;
            j_reg            <= '0;
            key_reg          <= '0;
            out_valid_reg    <= 1'b0;
            front_handle_reg <= '0;
            front_cost_reg   <= '0;
            count_out_reg    <= '0;
            empty_reg        <= 1'b1;
            err_out_reg      <= scd_pkg::ERR_NONE;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            cnt_reg          <= cnt_next;
            err_reg          <= err_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            key_reg          <= key_next;
            out_valid_reg    <= out_valid_next;
            front_handle_reg <= front_handle_next;
            front_cost_reg   <= front_cost_next;
            count_out_reg    <= count_out_next;
            empty_reg        <= empty_next;
            err_out_reg      <= err_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign front_handle = front_handle_reg;
    assign front_cost   = front_cost_reg;
    assign entry_count  = count_out_reg;
    assign is_empty     = empty_reg;
    assign error_code   = err_out_reg;

endmodule

>>> rtl/core/scd_checker.sv
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks for the sortable cost deque, bound to the deque module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [scd_pkg::IREF_W-1:0]   front_handle,
    input logic [scd_pkg::ICOST_W-1:0]  front_cost,
    input logic [scd_pkg::COUNT_W-1:0]  entry_count,
    input logic                         is_empty,
    input logic [scd_pkg::ERR_W-1:0]    error_code
);

    localparam int RW = scd_pkg::IREF_W + scd_pkg::ICOST_W + scd_pkg::COUNT_W
                        + 1 + scd_pkg::ERR_W;

    logic          pop_refused;
    logic          empty_zeroed;
    logic          out_stalled;
    logic [RW-1:0] result_word;

    assign pop_refused  = out_valid && (error_code == scd_pkg::ERR_POP_EMPTY);
    assign empty_zeroed = is_empty && (entry_count == '0) && (front_handle == '0)
                          && (front_cost == '0);
    assign out_stalled  = out_valid && out_stall;
    assign result_word  = {front_handle, front_cost, entry_count, is_empty, error_code};

    // An accepted action keeps the input side busy until its result is formed.
    `SCD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A fresh result only follows a cycle in which an action was in progress.
    `SCD_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // A refused pop leaves an empty list with zero front fields.
    `SCD_ASSERT_SAME(a_pop_empty_state, clk, rst_n, pop_refused, empty_zeroed)

    // A stalled result stays on the port unchanged.
    `SCD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_stalled, out_valid && $stable(result_word))

endmodule

bind sortable_cost_deque scd_checker u_scd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .front_handle (front_handle),
    .front_cost   (front_cost),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .error_code   (error_code)
);
